@@ rtl/fcpt_pkg.sv @@
// ============================================================================
// fcpt_pkg - shared types and constants of the Clarke/Park transform unit
// Item payloads for both channels and the fixed-point constants.
// ============================================================================
`default_nettype none

package fcpt_pkg;

  // 1/sqrt(3) in unsigned Q0.16, held as a positive signed value
  localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;

  // Exact floor division by three of a 17-bit magnitude: (u * K) >> 20.
  // K = ceil(2^20 / 3); the error term stays below 1/3 for any u < 2^19.
  localparam int unsigned         DIV3_SHIFT = 20;
  localparam logic [18:0]         DIV3_RECIP = 19'd349526;

  // Widths of the intermediate values
  localparam int unsigned SUM3_W = 19;  // 2a - b - c
  localparam int unsigned MAG_W  = 17;  // |2a - b - c| + 1
  localparam int unsigned DIFF_W = 17;  // b - c
  localparam int unsigned PROD_W = 32;  // Q1.15 x Q1.15
  localparam int unsigned SAT_W  = 40;  // input width of the clamp

  typedef struct packed {
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic signed [15:0] phase_c_current;
    logic signed [15:0] angle_sine;
    logic signed [15:0] angle_cosine;
    logic signed [15:0] voltage_d;
    logic signed [15:0] voltage_q;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] alpha_current;
    logic signed [15:0] beta_current;
    logic signed [15:0] d_current;
    logic signed [15:0] q_current;
    logic signed [15:0] alpha_voltage;
    logic signed [15:0] beta_voltage;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/fcpt_ifs.sv @@
// ============================================================================
// fcpt_ifs - item channels of the Clarke/Park transform unit
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface fcpt_in_if;
  logic               valid;
  logic               ready;
  fcpt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fcpt_out_if;
  logic                valid;
  logic                ready;
  fcpt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/foc_clarke_park_transforms_unit.sv @@
// ============================================================================
// foc_clarke_park_transforms_unit - Clarke, Park and inverse Park transforms
// Five-stage pipeline on signed Q1.15 items; one item in, one item out.
// ============================================================================
// Each input item gives one result item: alpha/beta currents from the
// three-current Clarke transform, d/q currents from the Park transform of
// the clamped alpha/beta, and alpha/beta voltages from the inverse Park
// transform of the d/q voltage commands. All results are rounded half up
// and clamped to 16 bits. Throughput is one item per clock cycle while
// out_ch is not stalled. An accepted item passes through all five register
// stages before it is offered on out_ch (the Clarke divide-by-three
// multiply and the Park multiply each sit after a registered stage of
// their own). Each stage advances when it is empty or the stage after it
// advances, so bubbles close up under a stall; in_ch.ready follows
// out_ch.ready combinationally through that chain. The block holds no
// state besides the pipeline and reset only clears the stage valid bits.
// ============================================================================
`default_nettype none

module foc_clarke_park_transforms_unit (
  input  wire              clk,
  input  wire              rst_n,
  fcpt_in_if.sink          in_ch,
  fcpt_out_if.source       out_ch
);

  // Clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [fcpt_pkg::SAT_W-1:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stage flow control
  // --------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  assign s5_en = !s5_vld_r || out_ch.ready;
  assign s4_en = !s4_vld_r || s5_en;
  assign s3_en = !s3_vld_r || s4_en;
  assign s2_en = !s2_vld_r || s3_en;
  assign s1_en = !s1_vld_r || s2_en;

  assign in_ch.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= in_ch.valid;
      if (s2_en) s2_vld_r <= s1_vld_r;
      if (s3_en) s3_vld_r <= s2_vld_r;
      if (s4_en) s4_vld_r <= s3_vld_r;
      if (s5_en) s5_vld_r <= s4_vld_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: Clarke sums, |2a-b-c|+1, voltage products
  // --------------------------------------------------------------------------
  logic signed [15:0] ia, ib, ic, sn, cs, vd, vq;
  assign ia = in_ch.data.phase_a_current;
  assign ib = in_ch.data.phase_b_current;
  assign ic = in_ch.data.phase_c_current;
  assign sn = in_ch.data.angle_sine;
  assign cs = in_ch.data.angle_cosine;
  assign vd = in_ch.data.voltage_d;
  assign vq = in_ch.data.voltage_q;

  logic signed [fcpt_pkg::SUM3_W-1:0] sum3;
  logic [fcpt_pkg::SUM3_W-1:0]        sum3_mag;
  logic                               s1_neg_nxt;
  logic [fcpt_pkg::MAG_W-1:0]         s1_mag_nxt;
  logic signed [fcpt_pkg::DIFF_W-1:0] s1_diff_nxt;
  logic signed [fcpt_pkg::PROD_W-1:0] s1_vdc_nxt, s1_vqs_nxt, s1_vds_nxt, s1_vqc_nxt;

  always_comb begin
    sum3        = 19'(ia) + 19'(ia) - 19'(ib) - 19'(ic);
    s1_neg_nxt  = sum3[fcpt_pkg::SUM3_W-1];
    sum3_mag    = s1_neg_nxt ? 19'(-sum3) : 19'(sum3);
    // magnitude never exceeds 131070, so +1 still fits
    s1_mag_nxt  = sum3_mag[fcpt_pkg::MAG_W-1:0] + 17'd1;
    s1_diff_nxt = 17'(ib) - 17'(ic);
    s1_vdc_nxt  = vd * cs;
    s1_vqs_nxt  = vq * sn;
    s1_vds_nxt  = vd * sn;
    s1_vqc_nxt  = vq * cs;
  end

  logic                               s1_neg_r;
  logic [fcpt_pkg::MAG_W-1:0]         s1_mag_r;
  logic signed [fcpt_pkg::DIFF_W-1:0] s1_diff_r;
  logic signed [15:0]                 s1_sn_r, s1_cs_r;
  logic signed [fcpt_pkg::PROD_W-1:0] s1_vdc_r, s1_vqs_r, s1_vds_r, s1_vqc_r;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_neg_r  <= s1_neg_nxt;
      s1_mag_r  <= s1_mag_nxt;
      s1_diff_r <= s1_diff_nxt;
      s1_sn_r   <= sn;
      s1_cs_r   <= cs;
      s1_vdc_r  <= s1_vdc_nxt;
      s1_vqs_r  <= s1_vqs_nxt;
      s1_vds_r  <= s1_vds_nxt;
      s1_vqc_r  <= s1_vqc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by three, scale by 1/sqrt3, finish inverse Park
  // --------------------------------------------------------------------------
  logic [fcpt_pkg::MAG_W+19:0]        div_prod;
  logic [fcpt_pkg::MAG_W-1:0]         s2_quo_nxt;
  logic signed [34:0]                 s2_bprod_nxt;
  logic signed [33:0]                 ua_sum, ub_sum;
  logic signed [33:0]                 ua_shf, ub_shf;
  logic signed [15:0]                 s2_ua_nxt, s2_ub_nxt;

  always_comb begin
    div_prod     = 37'(s1_mag_r) * 37'(fcpt_pkg::DIV3_RECIP);
    s2_quo_nxt   = div_prod[fcpt_pkg::DIV3_SHIFT +: fcpt_pkg::MAG_W];
    s2_bprod_nxt = 35'(s1_diff_r) * 35'(fcpt_pkg::INV_SQRT3_Q16);
    ua_sum       = 34'(s1_vdc_r) - 34'(s1_vqs_r) + 34'sd16384;
    ub_sum       = 34'(s1_vds_r) + 34'(s1_vqc_r) + 34'sd16384;
    ua_shf       = ua_sum >>> 15;
    ub_shf       = ub_sum >>> 15;
    s2_ua_nxt    = sat16(40'(ua_shf));
    s2_ub_nxt    = sat16(40'(ub_shf));
  end

  logic                       s2_neg_r;
  logic [fcpt_pkg::MAG_W-1:0] s2_quo_r;
  logic signed [34:0]         s2_bprod_r;
  logic signed [15:0]         s2_ua_r, s2_ub_r, s2_sn_r, s2_cs_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_neg_r   <= s1_neg_r;
      s2_quo_r   <= s2_quo_nxt;
      s2_bprod_r <= s2_bprod_nxt;
      s2_ua_r    <= s2_ua_nxt;
      s2_ub_r    <= s2_ub_nxt;
      s2_sn_r    <= s1_sn_r;
      s2_cs_r    <= s1_cs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: restore sign of alpha, round beta, clamp both
  // --------------------------------------------------------------------------
  logic signed [17:0] alpha_full;
  logic signed [34:0] beta_sum, beta_shf;
  logic signed [15:0] s3_alpha_nxt, s3_beta_nxt;

  always_comb begin
    alpha_full   = s2_neg_r ? -$signed({1'b0, s2_quo_r}) : $signed({1'b0, s2_quo_r});
    beta_sum     = s2_bprod_r + 35'sd32768;
    beta_shf     = beta_sum >>> 16;
    s3_alpha_nxt = sat16(40'(alpha_full));
    s3_beta_nxt  = sat16(40'(beta_shf));
  end

  logic signed [15:0] s3_alpha_r, s3_beta_r, s3_ua_r, s3_ub_r, s3_sn_r, s3_cs_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_alpha_r <= s3_alpha_nxt;
      s3_beta_r  <= s3_beta_nxt;
      s3_ua_r    <= s2_ua_r;
      s3_ub_r    <= s2_ub_r;
      s3_sn_r    <= s2_sn_r;
      s3_cs_r    <= s2_cs_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: Park products
  // --------------------------------------------------------------------------
  logic signed [fcpt_pkg::PROD_W-1:0] s4_ac_nxt, s4_bs_nxt, s4_bc_nxt, s4_as_nxt;

  always_comb begin
    s4_ac_nxt = s3_alpha_r * s3_cs_r;
    s4_bs_nxt = s3_beta_r * s3_sn_r;
    s4_bc_nxt = s3_beta_r * s3_cs_r;
    s4_as_nxt = s3_alpha_r * s3_sn_r;
  end

  logic signed [fcpt_pkg::PROD_W-1:0] s4_ac_r, s4_bs_r, s4_bc_r, s4_as_r;
  logic signed [15:0]                 s4_alpha_r, s4_beta_r, s4_ua_r, s4_ub_r;

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_ac_r    <= s4_ac_nxt;
      s4_bs_r    <= s4_bs_nxt;
      s4_bc_r    <= s4_bc_nxt;
      s4_as_r    <= s4_as_nxt;
      s4_alpha_r <= s3_alpha_r;
      s4_beta_r  <= s3_beta_r;
      s4_ua_r    <= s3_ua_r;
      s4_ub_r    <= s3_ub_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: Park sums, round, clamp into the output register
  // --------------------------------------------------------------------------
  logic signed [33:0]  id_sum, iq_sum, id_shf, iq_shf;
  fcpt_pkg::out_item_t s5_item_nxt;

  always_comb begin
    id_sum = 34'(s4_ac_r) + 34'(s4_bs_r) + 34'sd16384;
    iq_sum = 34'(s4_bc_r) - 34'(s4_as_r) + 34'sd16384;
    id_shf = id_sum >>> 15;
    iq_shf = iq_sum >>> 15;
    s5_item_nxt.alpha_current = s4_alpha_r;
    s5_item_nxt.beta_current  = s4_beta_r;
    s5_item_nxt.d_current     = sat16(40'(id_shf));
    s5_item_nxt.q_current     = sat16(40'(iq_shf));
    s5_item_nxt.alpha_voltage = s4_ua_r;
    s5_item_nxt.beta_voltage  = s4_ub_r;
  end

  fcpt_pkg::out_item_t s5_item_r;

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_item_r <= s5_item_nxt;
    end
  end

  assign out_ch.valid = s5_vld_r;
  assign out_ch.data  = s5_item_r;

endmodule

`default_nettype wire

@@ rtl/fcpt_checker.sv @@
// ============================================================================
// fcpt_checker - port-level checks of the Clarke/Park transform unit
// Reset, flow-control and latency properties seen at the channels.
// ============================================================================
`default_nettype none

module fcpt_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready
);

  // Output register empty after any reset cycle
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid set right after reset");

  // Empty output means nothing downstream can hold the pipeline
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // With the sink ready while an item passes through, the item reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("item not delivered on time");

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped under stall");

endmodule

bind foc_clarke_park_transforms_unit fcpt_checker u_fcpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

@@ sim/foc_clarke_park_transforms_unit_tb.sv @@
// ============================================================================
// foc_clarke_park_transforms_unit_tb - self-checking bench for the transforms
// Drives phase-current/angle/voltage items through valid/ready with random
// gaps and back-pressure, predicts every result in Q1.15 and compares it
// field by field against what the unit returns, in order.
// ============================================================================
`default_nettype none

module foc_clarke_park_transforms_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // --------------------------------------------------------------------------
  // Order book of predicted results. An accepted item is turned into its
  // expected result at once and queued; each result leaving the unit is
  // checked against the oldest entry.
  // --------------------------------------------------------------------------
  class transform_scoreboard;
    // 1/sqrt(3) in unsigned Q0.16
    localparam longint RECIP_SQRT3_Q16 = 37837;
    localparam int     MAX_REPORTS     = 10;

    fcpt_pkg::out_item_t expected_results[$];
    int                  mismatches;
    int                  checked;

    function int pending();
      return expected_results.size();
    endfunction

    // clamp to the signed 16-bit range
    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // add half an LSB and floor: round half towards plus infinity
    function longint round_shift(longint v, int unsigned s);
      longint half;
      half = longint'(1) <<< (s - 1);
      return (v + half) >>> s;
    endfunction

    function fcpt_pkg::out_item_t transform_sample(fcpt_pkg::in_item_t s);
      longint              ia, ib, ic, sn, cs, vd, vq, sum3, al, be;
      fcpt_pkg::out_item_t r;
      ia = s.phase_a_current;
      ib = s.phase_b_current;
      ic = s.phase_c_current;
      sn = s.angle_sine;
      cs = s.angle_cosine;
      vd = s.voltage_d;
      vq = s.voltage_q;

      // Clarke: nearest integer to (2a - b - c) / 3, symmetric about zero
      sum3 = 2 * ia - ib - ic;
      if (sum3 >= 0) al = (sum3 + 1) / 3;
      else           al = -((-sum3 + 1) / 3);
      al = clamp16(al);
      be = clamp16(round_shift((ib - ic) * RECIP_SQRT3_Q16, 16));

      r.alpha_current = al[15:0];
      r.beta_current  = be[15:0];
      // Park on the clamped alpha/beta; inverse Park on the voltage commands
      r.d_current     = 16'(clamp16(round_shift(al * cs + be * sn, 15)));
      r.q_current     = 16'(clamp16(round_shift(be * cs - al * sn, 15)));
      r.alpha_voltage = 16'(clamp16(round_shift(vd * cs - vq * sn, 15)));
      r.beta_voltage  = 16'(clamp16(round_shift(vd * sn + vq * cs, 15)));
      return r;
    endfunction

    function void note_sample(fcpt_pkg::in_item_t s);
      expected_results.push_back(transform_sample(s));
    endfunction

    function void compare_field(string name, logic signed [15:0] want,
                                logic signed [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("MISMATCH result %0d %s: expected %0d, got %0d",
                   checked, name, want, got);
      end
    endfunction

    function void check_result(fcpt_pkg::out_item_t got);
      fcpt_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("MISMATCH unexpected result item with nothing outstanding");
        return;
      end
      want = expected_results.pop_front();
      compare_field("alpha_current", want.alpha_current, got.alpha_current);
      compare_field("beta_current",  want.beta_current,  got.beta_current);
      compare_field("d_current",     want.d_current,     got.d_current);
      compare_field("q_current",     want.q_current,     got.q_current);
      compare_field("alpha_voltage", want.alpha_voltage, got.alpha_voltage);
      compare_field("beta_voltage",  want.beta_voltage,  got.beta_voltage);
      checked++;
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_PCT     = 16;
  localparam int DRAIN_CYCLES = 20;   // five pipeline stages, plus margin

  logic clk = 1'b0;
  logic rst_n;
  logic steady_phase;   // both sides run flat out while set
  int   sent_count;

  transform_scoreboard sb = new();

  fcpt_in_if  in_ch();
  fcpt_out_if out_ch();

  foc_clarke_park_transforms_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the pipeline hangs; far above the slowest legal run.
  initial begin
    #2ms;
    $display("timeout: %0d items sent, %0d still outstanding",
             sent_count, sb.pending());
    $display("foc_clarke_park_transforms_unit_tb failed");
    $finish;
  end

  // Accepted items on both channels are picked up at the rising edge, where
  // every handshake signal still holds the value driven at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.data);
  end

  // Result side back-pressure: ready dropped at random unless in the
  // steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic fcpt_pkg::in_item_t sample_of(
    logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] c,
    logic signed [15:0] sn, logic signed [15:0] cs,
    logic signed [15:0] vd, logic signed [15:0] vq);
    fcpt_pkg::in_item_t s;
    s.phase_a_current = a;
    s.phase_b_current = b;
    s.phase_c_current = c;
    s.angle_sine      = sn;
    s.angle_cosine    = cs;
    s.voltage_d       = vd;
    s.voltage_q       = vq;
    return s;
  endfunction

  // Field value biased towards the rails and towards tiny magnitudes, where
  // rounding and clamping matter most.
  function automatic logic signed [15:0] pick_field();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Plausible motor sample: balanced currents, a true sine/cosine pair.
  function automatic fcpt_pkg::in_item_t motor_sample();
    real                theta;
    int                 ia, ib;
    logic signed [15:0] sn, cs;
    theta = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
    sn = 16'($rtoi($sin(theta) * 32767.0));
    cs = 16'($rtoi($cos(theta) * 32767.0));
    ia = $signed($urandom_range(0, 32000)) - 16000;
    ib = $signed($urandom_range(0, 32000)) - 16000;
    return sample_of(16'(ia), 16'(ib), 16'(-ia - ib), sn, cs,
                     16'($urandom), 16'($urandom));
  endfunction

  // Present one item; valid is left high so back-to-back items need no
  // second assignment in the same step. Junk data rides on idle cycles.
  task automatic send_item(input fcpt_pkg::in_item_t item);
    @(negedge clk);
    while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      in_ch.data  = 112'({$urandom, $urandom, $urandom, $urandom});
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = item;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  initial begin
    rst_n        = 1'b0;
    steady_phase = 1'b0;
    sent_count   = 0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed corners ----
    send_item(sample_of(0, 0, 0, 0, 0, 0, 0));
    send_item(sample_of(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        16'sh7fff, 16'sh7fff));
    send_item(sample_of(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh8000));
    // alpha clamps high, then low
    send_item(sample_of(16'sh7fff, 16'sh8000, 16'sh8000, 0, 16'sh7fff, 0, 0));
    send_item(sample_of(16'sh8000, 16'sh7fff, 16'sh7fff, 0, 16'sh7fff, 0, 0));
    // beta clamps high, then low
    send_item(sample_of(0, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0, 0));
    send_item(sample_of(0, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0, 0));
    // divide-by-three rounding on either side of zero
    send_item(sample_of(1, 0, 0, 0, 16'sh7fff, 0, 0));
    send_item(sample_of(0, 1, 0, 0, 16'sh7fff, 0, 0));
    send_item(sample_of(-1, 0, 0, 0, 16'sh7fff, 0, 0));
    send_item(sample_of(0, 0, 2, 0, 16'sh7fff, 0, 0));
    // beta rounding for the smallest differences
    send_item(sample_of(0, 1, 0, 16'sh7fff, 16'sh7fff, 0, 0));
    send_item(sample_of(0, -1, 0, 16'sh7fff, 16'sh7fff, 0, 0));
    // Park and inverse Park overflow with inconsistent sine/cosine
    send_item(sample_of(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh8000));
    send_item(sample_of(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                        16'sh7fff, 16'sh8000));
    send_item(sample_of(0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000));
    send_item(sample_of(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
    // exact half LSB in the voltage path: rounds up on both signs
    send_item(sample_of(0, 0, 0, 0, 16384, 1, 0));
    send_item(sample_of(0, 0, 0, 0, 16384, -1, 0));
    send_item(sample_of(0, 0, 0, 16384, 0, 0, -1));
    // ordinary balanced operating point
    send_item(sample_of(16384, -8192, -8192, 0, 16'sh7fff, 8192, -8192));

    // ---- random items ----
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_phase = (i >= 150 && i < 250);
      case ($urandom_range(0, 3))
        0, 1: send_item(motor_sample());
        default:
          send_item(sample_of(pick_field(), pick_field(), pick_field(),
                              pick_field(), pick_field(), pick_field(),
                              pick_field()));
      endcase
    end
    steady_phase = 1'b0;
    @(negedge clk);
    in_ch.valid = 1'b0;

    // drain, then give stray results a chance to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent incl. rail, rounding and clamp corners", sent_count);
    $display("%0d results checked, %0d field mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0 && sb.checked == sent_count) begin
      $display("foc_clarke_park_transforms_unit_tb passed");
    end else begin
      $display("foc_clarke_park_transforms_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
